// ----- design/mcrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcrd_pkg
// types, widths and the constant path count table of the chunk rank delta
// ----------------------------------------------------------------------------
`default_nettype none

package mcrd_pkg;

    localparam int CHUNK_W  = 2;
    localparam int HEIGHT_W = 5;
    localparam int SYM_W    = 8;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 24;
    localparam int RANK_W   = 24;
    localparam int ACC_W    = 28;
    localparam int ROWS     = 16;
    localparam int COLS     = 32;
    localparam int STEPS    = 4;

    localparam logic [CHUNK_W-1:0] LAST_CHUNK = 2'd2;
    localparam logic [POS_W-1:0]   TOP_POS    = 4'd14;

    localparam logic [1:0] SYM_FLAT    = 2'd0;
    localparam logic [1:0] SYM_DOWN    = 2'd1;
    localparam logic [1:0] SYM_UP      = 2'd2;
    localparam logic [1:0] SYM_ILLEGAL = 2'd3;

    typedef logic [ROWS-1:0][COLS-1:0][CNT_W-1:0] cnt_tbl_t;

    typedef struct packed {
        logic [CHUNK_W-1:0]  chunk_index;
        logic [HEIGHT_W-1:0] start_height;
        logic [SYM_W-1:0]    symbols;
    } item_t;

    typedef struct packed {
        logic                    bad;
        logic [HEIGHT_W-1:0]     height;
        logic signed [ACC_W-1:0] delta;
    } walk_state_t;

    typedef struct packed {
        logic                     rejected;
        logic signed [RANK_W-1:0] rank_delta;
        logic [HEIGHT_W-1:0]      end_height;
    } result_t;

    // motzkin path counts: row is the remaining length, column the height
    function automatic cnt_tbl_t build_cnt_tbl();
        cnt_tbl_t t;
        logic [CNT_W:0] s;
        t = '0;
        t[0][0] = CNT_W'(1);
        for (int w = 1; w < ROWS; w++)
        begin
            for (int h = 0; h < COLS; h++)
            begin
                s = {1'b0, t[w-1][h]};
                if (h > 0)
                begin
                    s = s + {1'b0, t[w-1][h-1]};
                end
                if (h + 1 < COLS)
                begin
                    s = s + {1'b0, t[w-1][h+1]};
                end
                t[w][h] = s[CNT_W-1:0];
            end
        end
        return t;
    endfunction

    localparam cnt_tbl_t CNT_TBL = build_cnt_tbl();

endpackage

`default_nettype wire

// ----- design/motzkin_chunk_rank_delta.sv -----
// ----------------------------------------------------------------------------
// motzkin_chunk_rank_delta
// enumerative rank change of one four-symbol motzkin path chunk
// ----------------------------------------------------------------------------
// One item per clock cycle is taken while the output side takes results, and
// one result per item is given: the item goes into an input register, the
// four chained symbol steps (each four lookups in the constant path count
// table and a few adds) evaluate between it and the result register, and the
// result register drives the output stream. Either stage refills in the cycle
// it empties; while a result waits, the input register takes at most one more
// item and then holds tready low until the output side takes the result.
// MAX_WIDTH sets the highest reachable height, MAX_WIDTH+1; a chunk that starts
// or steps above it, steps below zero, holds an illegal symbol, names chunk
// three or gives a delta outside 24 signed bits is rejected with zero delta
// and height.
// ----------------------------------------------------------------------------
`default_nettype none

module motzkin_chunk_rank_delta
    import mcrd_pkg::*;
#(
    parameter int MAX_WIDTH = 28
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // chunk_index[1:0], start_height[6:2], symbols[14:7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // rank_delta[23:0], end_height[28:24]
    output logic [0:0]  m_axis_tuser    // rejected[0]
);

    logic    in_valid_reg;
    logic    res_valid_reg;
    item_t   item_reg;
    result_t res_reg;
    item_t   item_next;
    result_t res_next;
    logic    in_ready;
    logic    res_ready;

    assign res_ready = !res_valid_reg || m_axis_tready;
    assign in_ready  = !in_valid_reg || res_ready;

    assign item_next.chunk_index  = s_axis_tdata[1:0];
    assign item_next.start_height = s_axis_tdata[6:2];
    assign item_next.symbols      = s_axis_tdata[14:7];

    mcrd_walk #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_walk (
        .item   (item_reg),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (res_ready)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && in_ready)
        begin
            item_reg <= item_next;
        end
        if (in_valid_reg && res_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {3'b000, res_reg.end_height, res_reg.rank_delta};
    assign m_axis_tuser  = res_reg.rejected;

endmodule

`default_nettype wire

// ----- design/mcrd_step.sv -----
// ----------------------------------------------------------------------------
// mcrd_step
// one path symbol: table lookups, rank difference and height update
// ----------------------------------------------------------------------------
`default_nettype none

module mcrd_step
    import mcrd_pkg::*;
#(
    parameter int MAX_WIDTH = 28
)
(
    input  walk_state_t      state_in,
    input  logic [1:0]       sym,
    input  logic [POS_W-1:0] pos,
    output walk_state_t      state_out
);

    localparam logic [HEIGHT_W-1:0] H_TOP = HEIGHT_W'(MAX_WIDTH + 1);

    logic [POS_W-1:0]    pos_m1;
    logic [HEIGHT_W-1:0] h;
    logic [HEIGHT_W-1:0] h_m1;
    logic                h_zero;
    logic [CNT_W-1:0]    lo_h;
    logic [CNT_W-1:0]    lo_hm1;
    logic [CNT_W-1:0]    hi_h;
    logic [CNT_W-1:0]    hi_hm1;
    logic [CNT_W:0]      lo_pair;
    logic [CNT_W:0]      hi_pair;
    logic signed [ACC_W-1:0] down_diff;
    logic signed [ACC_W-1:0] up_diff;

    assign pos_m1 = pos - POS_W'(1);
    assign h      = state_in.height;
    assign h_m1   = h - HEIGHT_W'(1);
    assign h_zero = (h == '0);

    // lo is the row one shorter than the current position
    assign lo_h   = CNT_TBL[pos_m1][h];
    assign hi_h   = CNT_TBL[pos][h];
    assign lo_hm1 = h_zero ? '0 : CNT_TBL[pos_m1][h_m1];
    assign hi_hm1 = h_zero ? '0 : CNT_TBL[pos][h_m1];

    assign lo_pair = {1'b0, lo_h} + {1'b0, lo_hm1};
    assign hi_pair = {1'b0, hi_h} + {1'b0, hi_hm1};

    assign down_diff = $signed({{(ACC_W-CNT_W){1'b0}}, lo_h})
                     - $signed({{(ACC_W-CNT_W){1'b0}}, hi_h});
    assign up_diff   = $signed({{(ACC_W-CNT_W-1){1'b0}}, lo_pair})
                     - $signed({{(ACC_W-CNT_W-1){1'b0}}, hi_pair});

    always_comb
    begin
        state_out = state_in;
        unique case (sym)
            SYM_FLAT:
            begin
                state_out = state_in;
            end
            SYM_DOWN:
            begin
                if (h_zero)
                begin
                    state_out.bad = 1'b1;
                end
                else
                begin
                    state_out.delta  = state_in.delta + down_diff;
                    state_out.height = h_m1;
                end
            end
            SYM_UP:
            begin
                if (h >= H_TOP)
                begin
                    state_out.bad = 1'b1;
                end
                else
                begin
                    state_out.delta  = state_in.delta + up_diff;
                    state_out.height = h + HEIGHT_W'(1);
                end
            end
            SYM_ILLEGAL:
            begin
                state_out.bad = 1'b1;
            end
            default:
            begin
                state_out.bad = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/mcrd_walk.sv -----
// ----------------------------------------------------------------------------
// mcrd_walk
// walks the four symbols of a chunk, checks chunk index, start height and delta range
// ----------------------------------------------------------------------------
`default_nettype none

module mcrd_walk
    import mcrd_pkg::*;
#(
    parameter int MAX_WIDTH = 28
)
(
    input  item_t   item,
    output result_t result
);

    localparam logic [HEIGHT_W-1:0] H_TOP = HEIGHT_W'(MAX_WIDTH + 1);

    walk_state_t      chain [STEPS+1];
    logic [CHUNK_W-1:0] chunk_eff;
    logic [POS_W-1:0]   top_pos;
    logic [ACC_W-RANK_W:0] sign_bits;
    logic               out_of_range;
    logic               bad;

    assign chunk_eff = (item.chunk_index > LAST_CHUNK) ? '0 : item.chunk_index;
    assign top_pos   = TOP_POS - {chunk_eff, 2'b00};

    assign chain[0].bad    = (item.chunk_index > LAST_CHUNK) || (item.start_height > H_TOP);
    assign chain[0].height = item.start_height;
    assign chain[0].delta  = '0;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        mcrd_step #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_step (
            .state_in  (chain[k]),
            .sym       (item.symbols[SYM_W-1-2*k -: 2]),
            .pos       (top_pos - POS_W'(k)),
            .state_out (chain[k+1])
        );
    end

    // in range when the bits from 23 up all agree
    assign sign_bits    = chain[STEPS].delta[ACC_W-1:RANK_W-1];
    assign out_of_range = (sign_bits != '0) && (sign_bits != '1);
    assign bad          = chain[STEPS].bad || out_of_range;

    assign result.rejected   = bad;
    assign result.rank_delta = bad ? '0 : chain[STEPS].delta[RANK_W-1:0];
    assign result.end_height = bad ? '0 : chain[STEPS].height;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking regression of the motzkin chunk rank delta stream block
// ----------------------------------------------------------------------------
// A table of directed chunks covers the field extremes, every symbol kind,
// illegal symbols, blocked steps, chunk three and unreachable start heights.
// Random chunks follow, mostly legal walks with random content and some raw
// noise. Every accepted item gets an expected result, typed in the table or
// predicted from a local path count table. Each result is compared field by
// field with the oldest expectation. Both sides idle at random, with calm stretches in between.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import mcrd_pkg::*;
;

    localparam int MAX_W       = 28;
    localparam int PEAK_HEIGHT = MAX_W + 1;
    localparam int CNT_ROWS    = 15;
    localparam int CNT_COLS    = MAX_W + 3;
    localparam longint DELTA_SPAN = longint'(1) << (RANK_W - 1);
    localparam int RANDOM_ITEMS = 1900;

    typedef struct {
        logic [CHUNK_W-1:0]  chunk;
        logic [HEIGHT_W-1:0] height;
        logic [SYM_W-1:0]    syms;
        bit                  typed;
        result_t             want;
    } chunk_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // chunk_index[1:0], start_height[6:2], symbols[14:7]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // rank_delta[23:0], end_height[28:24]
    logic [0:0]  m_axis_tuser;         // rejected[0]

    longint     path_cnt [0:CNT_ROWS-1][0:CNT_COLS-1];
    result_t    pending_results [$];
    chunk_row_t directed_rows [$];
    int         mismatch_count = 0;
    bit         calm = 1'b0;

    motzkin_chunk_rank_delta #(
        .MAX_WIDTH (MAX_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("motzkin_chunk_rank_delta regression: fail");
        $finish;
    end

    // path counts: row is the remaining length, column the height
    initial
    begin
        longint s;
        for (int h = 0; h < CNT_COLS; h++)
        begin
            path_cnt[0][h] = (h == 0) ? 1 : 0;
        end
        for (int w = 1; w < CNT_ROWS; w++)
        begin
            for (int h = 0; h < CNT_COLS; h++)
            begin
                s = path_cnt[w-1][h];
                if (h > 0)
                begin
                    s += path_cnt[w-1][h-1];
                end
                if (h + 1 < CNT_COLS)
                begin
                    s += path_cnt[w-1][h+1];
                end
                path_cnt[w][h] = s;
            end
        end
    end

    function automatic longint paired_count(int w, int h);
        return path_cnt[w][h] + ((h > 0) ? path_cnt[w][h-1] : 0);
    endfunction

    function automatic result_t predict_rank_delta(item_t it);
        result_t    r;
        int         h;
        int         pos;
        longint     d;
        bit         bad;
        logic [1:0] s;
        h   = int'(it.start_height);
        d   = 0;
        bad = (it.chunk_index > LAST_CHUNK) || (h > PEAK_HEIGHT);
        for (int k = 0; k < STEPS; k++)
        begin
            if (!bad)
            begin
                pos = int'(TOP_POS) - 4 * int'(it.chunk_index) - k;
                s   = it.symbols[SYM_W-1-2*k -: 2];
                case (s)
                    SYM_ILLEGAL:
                    begin
                        bad = 1'b1;
                    end
                    SYM_DOWN:
                    begin
                        if (h == 0)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            d += path_cnt[pos-1][h] - path_cnt[pos][h];
                            h--;
                        end
                    end
                    SYM_UP:
                    begin
                        if (h >= PEAK_HEIGHT)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            d += paired_count(pos - 1, h) - paired_count(pos, h);
                            h++;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        if (!bad && (d < -DELTA_SPAN || d >= DELTA_SPAN))
        begin
            bad = 1'b1;
        end
        r = '0;
        if (bad)
        begin
            r.rejected = 1'b1;
        end
        else
        begin
            r.rank_delta = d[RANK_W-1:0];
            r.end_height = h[HEIGHT_W-1:0];
        end
        return r;
    endfunction

    task automatic add_row(input logic [CHUNK_W-1:0] chunk, input logic [HEIGHT_W-1:0] height,
                           input logic [SYM_W-1:0] syms, input bit typed,
                           input bit rej, input int delta, input int end_h);
        chunk_row_t row;
        row.chunk               = chunk;
        row.height              = height;
        row.syms                = syms;
        row.typed               = typed;
        row.want.rejected       = rej;
        row.want.rank_delta     = delta[RANK_W-1:0];
        row.want.end_height     = end_h[HEIGHT_W-1:0];
        directed_rows.push_back(row);
    endtask

    // called just after a rising edge; returns at the edge that takes the item
    task automatic drive_item(input item_t it, input result_t want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.symbols, it.start_height, it.chunk_index};
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
        pending_results.push_back(want);
    endtask

    initial
    begin : item_source
        item_t   it;
        int      h;
        int      pick;
        logic [1:0] s;
        // refused chunks
        add_row(2'd3, 5'd0,  8'h00, 1'b1, 1'b1, 0, 0);
        add_row(2'd0, 5'd30, 8'h00, 1'b1, 1'b1, 0, 0);
        add_row(2'd1, 5'd31, 8'h00, 1'b1, 1'b1, 0, 0);
        add_row(2'd0, 5'd5,  8'hC0, 1'b1, 1'b1, 0, 0);
        add_row(2'd1, 5'd5,  8'h30, 1'b1, 1'b1, 0, 0);
        add_row(2'd2, 5'd5,  8'h0C, 1'b1, 1'b1, 0, 0);
        add_row(2'd0, 5'd5,  8'h03, 1'b1, 1'b1, 0, 0);
        add_row(2'd2, 5'd1,  8'hFF, 1'b1, 1'b1, 0, 0);
        add_row(2'd0, 5'd0,  8'h40, 1'b1, 1'b1, 0, 0);
        add_row(2'd1, 5'd29, 8'h80, 1'b1, 1'b1, 0, 0);
        add_row(2'd0, 5'd26, 8'hAA, 1'b1, 1'b1, 0, 0);
        // flat chunks keep the height
        add_row(2'd0, 5'd0,  8'h00, 1'b1, 1'b0, 0, 0);
        add_row(2'd2, 5'd29, 8'h00, 1'b1, 1'b0, 0, 29);
        // walks left to the predictor
        add_row(2'd0, 5'd25, 8'hAA, 1'b0, 1'b0, 0, 0);
        add_row(2'd0, 5'd0,  8'hAA, 1'b0, 1'b0, 0, 0);
        add_row(2'd1, 5'd0,  8'hAA, 1'b0, 1'b0, 0, 0);
        add_row(2'd2, 5'd0,  8'hAA, 1'b0, 1'b0, 0, 0);
        add_row(2'd0, 5'd4,  8'h55, 1'b0, 1'b0, 0, 0);
        add_row(2'd2, 5'd4,  8'h55, 1'b0, 1'b0, 0, 0);
        add_row(2'd0, 5'd0,  8'h99, 1'b0, 1'b0, 0, 0);
        add_row(2'd1, 5'd3,  8'h66, 1'b0, 1'b0, 0, 0);
        add_row(2'd0, 5'd29, 8'h55, 1'b0, 1'b0, 0, 0);
        add_row(2'd2, 5'd28, 8'h24, 1'b0, 1'b0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            it.chunk_index  = directed_rows[i].chunk;
            it.start_height = directed_rows[i].height;
            it.symbols      = directed_rows[i].syms;
            drive_item(it, directed_rows[i].typed ? directed_rows[i].want
                                                  : predict_rank_delta(it));
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            // hold off until the block has drained
            if (i == RANDOM_ITEMS / 2)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                it.chunk_index  = CHUNK_W'($urandom_range(0, 2));
                it.start_height = HEIGHT_W'($urandom_range(0, PEAK_HEIGHT));
                h = int'(it.start_height);
                for (int k = 0; k < STEPS; k++)
                begin
                    case ($urandom_range(0, 2))
                        0:       s = SYM_FLAT;
                        1:       s = (h > 0) ? SYM_DOWN : SYM_UP;
                        default: s = (h < PEAK_HEIGHT) ? SYM_UP : SYM_DOWN;
                    endcase
                    if (s == SYM_DOWN)
                    begin
                        h--;
                    end
                    else if (s == SYM_UP)
                    begin
                        h++;
                    end
                    it.symbols[SYM_W-1-2*k -: 2] = s;
                end
            end
            else
            begin
                it.chunk_index  = CHUNK_W'($urandom_range(0, 3));
                it.start_height = HEIGHT_W'($urandom_range(0, 31));
                it.symbols      = SYM_W'($urandom_range(0, 255));
            end
            drive_item(it, predict_rank_delta(it));
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("motzkin_chunk_rank_delta regression: pass");
        end
        else
        begin
            $display("motzkin_chunk_rank_delta regression: fail");
        end
        $finish;
    end

    initial
    begin : result_sink
        int      stall;
        result_t got;
        result_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
            got.rejected   = m_axis_tuser[0];
            got.rank_delta = m_axis_tdata[RANK_W-1:0];
            got.end_height = m_axis_tdata[24 +: HEIGHT_W];
            if (pending_results.size() == 0)
            begin
                $error("result item with none pending: rejected %0d, rank_delta %0d, %s %0d",
                       got.rejected, got.rank_delta, "end_height", got.end_height);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.rejected !== want.rejected)
                begin
                    $error("rejected: expected %0d, actual %0d", want.rejected, got.rejected);
                    mismatch_count++;
                end
                if (got.rank_delta !== want.rank_delta)
                begin
                    $error("rank_delta: expected %0d, actual %0d",
                           want.rank_delta, got.rank_delta);
                    mismatch_count++;
                end
                if (got.end_height !== want.end_height)
                begin
                    $error("end_height: expected %0d, actual %0d",
                           want.end_height, got.end_height);
                    mismatch_count++;
                end
            end
        end
    end

endmodule

`default_nettype wire
